### rtl/core/distance_lru_slot_cache_top_macros.svh
// Assertion macros shared by the block's modules.
`ifndef DISTANCE_LRU_SLOT_CACHE_TOP_MACROS_SVH
`define DISTANCE_LRU_SLOT_CACHE_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define CHK_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`define CHK_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CHK_NEVER(lbl, clk, rst_n, cond, msg)

`define CHK_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`define CHK_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/core/dlsc_pkg.sv
package dlsc_pkg;

	localparam int TAG_W = 16;
	localparam int ST_W = 2;
	localparam int OUT_SLOT_W = 5;
	localparam int DIST_W = 5;

	localparam logic [ST_W-1:0] ST_PENDING = 2'd0;
	localparam logic [ST_W-1:0] ST_LOADED = 2'd1;
	localparam logic [ST_W-1:0] ST_MISSING = 2'd2;

	localparam logic [3:0] RADIUS_RESET = 4'd6;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_PICK = 2'd1,
		OP_REPORT = 2'd2,
		OP_FLUSH = 2'd3
	} op_t;

	typedef enum logic {
		CFG_ITEM_COUNT = 1'b0,
		CFG_RADIUS = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_PREF,
		S_RPT_RD,
		S_RPT_EV,
		S_FLUSH
	} state_t;

	typedef enum logic [2:0] {
		RES_ZERO,
		RES_MATCH,
		RES_CLAIM,
		RES_PEND,
		RES_PREF,
		RES_REPORT
	} res_sel_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic pref_step;
		logic rpt_read;
		logic flush;
		logic emit;
		res_sel_t res_sel;
	} cmd_t;

	typedef struct packed {
		op_t op;
		logic scan_end;
		logic match;
		logic pend;
		logic zero_count;
		logic pref_ok;
		logic pref_end;
	} status_t;

endpackage

### rtl/core/distance_lru_slot_cache_top.sv
// Sequence: a lookup scans every slot, decides, then registers its result on done; a pick may
// add a prefetch search, one candidate index per cycle; report reads one slot; flush clears all.
// Throughput: one item at a time; the slot scan reads the tag memory once per cycle.
// done pulses for one cycle with the result; the receiver cannot stall it.
// Reset: arst_n clears every slot valid bit, item_count to 0, prefetch_radius to 6.
module distance_lru_slot_cache_top import dlsc_pkg::*; #(
	parameter int SLOT_COUNT = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [TAG_W-1:0]      cfg_data,
	input  logic                  start,
	input  logic [1:0]            op,
	input  logic [TAG_W-1:0]      target_index,
	input  logic [TAG_W-1:0]      item_index,
	input  logic [OUT_SLOT_W-1:0] report_slot,
	input  logic                  load_ok,
	output logic                  busy,
	output logic                  done,
	output logic [OUT_SLOT_W-1:0] slot_index,
	output logic [TAG_W-1:0]      slot_item,
	output logic                  hit,
	output logic [ST_W-1:0]       load_state,
	output logic                  found
);

	cmd_t cmd;
	status_t status;

	dlsc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.op       (op_t'(op)),
		.status_i (status),
		.cmd_o    (cmd),
		.busy     (busy)
	);

	dlsc_datapath #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.op           (op_t'(op)),
		.target_index (target_index),
		.item_index   (item_index),
		.report_slot  (report_slot),
		.load_ok      (load_ok),
		.cmd_i        (cmd),
		.status_o     (status),
		.done         (done),
		.slot_index   (slot_index),
		.slot_item    (slot_item),
		.hit          (hit),
		.load_state   (load_state),
		.found        (found)
	);

endmodule

### rtl/core/dlsc_ctrl.sv
`include "distance_lru_slot_cache_top_macros.svh"

module dlsc_ctrl import dlsc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  op_t     op,
	input  status_t status_i,
	output cmd_t    cmd_o,
	output logic    busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd_o = '0;
		cmd_o.res_sel = RES_ZERO;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_o.load = 1'b1;
					unique case (op)
						OP_LOOKUP: state_d = S_SCAN;
						OP_PICK: state_d = S_SCAN;
						OP_REPORT: state_d = S_RPT_RD;
						OP_FLUSH: state_d = S_FLUSH;
					endcase
				end
			end
			S_SCAN: begin
				cmd_o.scan = 1'b1;
				if (status_i.scan_end) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				priority if (status_i.op == OP_LOOKUP) begin
					cmd_o.emit = 1'b1;
					cmd_o.res_sel = status_i.match ? RES_MATCH : RES_CLAIM;
					state_d = S_IDLE;
				end else if (status_i.zero_count) begin
					cmd_o.emit = 1'b1;
					cmd_o.res_sel = RES_ZERO;
					state_d = S_IDLE;
				end else if (status_i.pend) begin
					cmd_o.emit = 1'b1;
					cmd_o.res_sel = RES_PEND;
					state_d = S_IDLE;
				end else begin
					state_d = S_PREF;
				end
			end
			S_PREF: begin
				priority if (status_i.pref_end) begin
					cmd_o.emit = 1'b1;
					cmd_o.res_sel = RES_ZERO;
					state_d = S_IDLE;
				end else if (status_i.pref_ok) begin
					cmd_o.emit = 1'b1;
					cmd_o.res_sel = RES_PREF;
					state_d = S_IDLE;
				end else begin
					cmd_o.pref_step = 1'b1;
				end
			end
			S_RPT_RD: begin
				cmd_o.rpt_read = 1'b1;
				state_d = S_RPT_EV;
			end
			S_RPT_EV: begin
				cmd_o.emit = 1'b1;
				cmd_o.res_sel = RES_REPORT;
				state_d = S_IDLE;
			end
			S_FLUSH: begin
				cmd_o.flush = 1'b1;
				cmd_o.emit = 1'b1;
				cmd_o.res_sel = RES_ZERO;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

	`CHK_NEXT(emit_ends_item, clk, arst_n, cmd_o.emit, state_q == S_IDLE, "emit did not end the item")
	`CHK_NEXT(accept_leaves_idle, clk, arst_n, start && state_q == S_IDLE, state_q != S_IDLE, "accepted item left controller idle")
	`CHK_IMPLIES(decide_after_scan, clk, arst_n, state_q == S_DECIDE, $past(state_q) == S_SCAN, "decide entered without a scan")

endmodule

### rtl/core/dlsc_datapath.sv
`include "distance_lru_slot_cache_top_macros.svh"

module dlsc_datapath import dlsc_pkg::*; #(
	parameter int SLOT_COUNT = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [TAG_W-1:0]      cfg_data,
	input  op_t                   op,
	input  logic [TAG_W-1:0]      target_index,
	input  logic [TAG_W-1:0]      item_index,
	input  logic [OUT_SLOT_W-1:0] report_slot,
	input  logic                  load_ok,
	input  cmd_t                  cmd_i,
	output status_t               status_o,
	output logic                  done,
	output logic [OUT_SLOT_W-1:0] slot_index,
	output logic [TAG_W-1:0]      slot_item,
	output logic                  hit,
	output logic [ST_W-1:0]       load_state,
	output logic                  found
);

	localparam int SW = $clog2(SLOT_COUNT);
	localparam int CW = $clog2(SLOT_COUNT + 1);
	localparam int WW = TAG_W + ST_W;
	localparam logic [CW-1:0] LAST_CNT = CW'(SLOT_COUNT);

	logic [TAG_W-1:0] item_count_q;
	logic [3:0] radius_q;

	op_t op_q;
	logic [TAG_W-1:0] target_q;
	logic [TAG_W-1:0] item_q;
	logic [OUT_SLOT_W-1:0] rslot_q;
	logic ok_q;

	logic [WW-1:0] slot_mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;

	logic [CW-1:0] cnt_q;
	logic eval_s1;
	logic [SW-1:0] idx_s1;
	logic [WW-1:0] rd_s1;

	logic match_q;
	logic [SW-1:0] match_idx_q;
	logic [ST_W-1:0] match_st_q;
	logic free_q;
	logic [SW-1:0] free_idx_q;
	logic far_q;
	logic [SW-1:0] far_idx_q;
	logic [TAG_W-1:0] far_d_q;
	logic pend_q;
	logic [SW-1:0] pend_idx_q;
	logic [TAG_W-1:0] pend_d_q;
	logic [TAG_W-1:0] pend_tag_q;
	logic [15:0] plus_map_q;
	logic [15:0] minus_map_q;

	logic [DIST_W-1:0] pd_q;
	logic psgn_q;

	logic [TAG_W-1:0] rd_tag;
	logic [ST_W-1:0] rd_st;
	logic rd_v;
	logic [TAG_W:0] diff_up;
	logic [TAG_W-1:0] diff_dn;
	logic [TAG_W-1:0] tag_gap;
	logic plus_near;
	logic minus_near;

	logic [SW-1:0] claim_idx;
	logic rd_en;
	logic [SW-1:0] rd_addr;
	logic rpt_in;
	logic rpt_apply;
	logic [ST_W-1:0] rpt_st;

	logic [TAG_W:0] cand;
	logic skip_minus;
	logic cand_below;
	logic slotted;
	logic pref_end;

	logic mem_we;
	logic [SW-1:0] mem_wa;
	logic [WW-1:0] mem_wd;
	logic claim_we;

	logic [OUT_SLOT_W-1:0] res_slot;
	logic [TAG_W-1:0] res_item;
	logic res_hit;
	logic [ST_W-1:0] res_st;
	logic res_found;

	logic done_q;
	logic [OUT_SLOT_W-1:0] slot_index_q;
	logic [TAG_W-1:0] slot_item_q;
	logic hit_q;
	logic [ST_W-1:0] load_state_q;
	logic found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= '0;
			radius_q <= RADIUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_ITEM_COUNT: item_count_q <= cfg_data;
				CFG_RADIUS: radius_q <= cfg_data[3:0];
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			op_q <= op;
			target_q <= target_index;
			item_q <= item_index;
			rslot_q <= report_slot;
			ok_q <= load_ok;
		end
	end

	assign rd_tag = rd_s1[WW-1:ST_W];
	assign rd_st = rd_s1[ST_W-1:0];
	assign rd_v = valid_q[idx_s1];
	assign diff_up = {1'b0, rd_tag} - {1'b0, target_q};
	assign diff_dn = target_q - rd_tag;
	assign tag_gap = diff_up[TAG_W] ? diff_dn : diff_up[TAG_W-1:0];
	assign plus_near = !diff_up[TAG_W] && (diff_up[TAG_W-1:4] == '0);
	assign minus_near = diff_up[TAG_W] && (diff_dn[TAG_W-1:4] == '0);

	assign claim_idx = free_q ? free_idx_q : far_idx_q;
	assign rpt_in = ({2'b00, rslot_q} < 7'(SLOT_COUNT));
	assign rd_en = (cmd_i.rpt_read && rpt_in) || (cmd_i.scan && (cnt_q < LAST_CNT));
	assign rd_addr = cmd_i.rpt_read ? SW'(rslot_q) : cnt_q[SW-1:0];
	assign rpt_apply = rpt_in && rd_v && (rd_tag == item_q);
	assign rpt_st = ok_q ? ST_LOADED : ST_MISSING;

	assign cand = psgn_q ? ({1'b0, target_q} - (TAG_W + 1)'(pd_q))
	                     : ({1'b0, target_q} + (TAG_W + 1)'(pd_q));
	assign skip_minus = psgn_q && ((pd_q == '0) || (TAG_W'(pd_q) > target_q));
	assign cand_below = (cand < {1'b0, item_count_q});
	assign slotted = psgn_q ? minus_map_q[pd_q[3:0]] : plus_map_q[pd_q[3:0]];
	assign pref_end = (pd_q > {1'b0, radius_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			eval_s1 <= 1'b0;
			idx_s1 <= '0;
			pd_q <= '0;
			psgn_q <= 1'b0;
		end else begin
			eval_s1 <= cmd_i.scan && (cnt_q < LAST_CNT);
			if (cmd_i.load) begin
				cnt_q <= '0;
				pd_q <= '0;
				psgn_q <= 1'b0;
			end
			if (cmd_i.scan && (cnt_q < LAST_CNT)) begin
				cnt_q <= cnt_q + 1'b1;
				idx_s1 <= cnt_q[SW-1:0];
			end
			if (cmd_i.rpt_read) begin
				idx_s1 <= SW'(rslot_q);
			end
			if (cmd_i.pref_step) begin
				if (psgn_q) begin
					pd_q <= pd_q + 1'b1;
				end
				psgn_q <= !psgn_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			match_idx_q <= '0;
			match_st_q <= '0;
			free_q <= 1'b0;
			free_idx_q <= '0;
			far_q <= 1'b0;
			far_idx_q <= '0;
			far_d_q <= '0;
			pend_q <= 1'b0;
			pend_idx_q <= '0;
			pend_d_q <= '0;
			pend_tag_q <= '0;
			plus_map_q <= '0;
			minus_map_q <= '0;
		end else if (cmd_i.load) begin
			match_q <= 1'b0;
			free_q <= 1'b0;
			far_q <= 1'b0;
			pend_q <= 1'b0;
			plus_map_q <= '0;
			minus_map_q <= '0;
		end else if (eval_s1) begin
			if (!rd_v) begin
				if (!free_q) begin
					free_q <= 1'b1;
					free_idx_q <= idx_s1;
				end
			end else begin
				if (!match_q && (rd_tag == item_q)) begin
					match_q <= 1'b1;
					match_idx_q <= idx_s1;
					match_st_q <= rd_st;
				end
				if (!far_q || (tag_gap > far_d_q)) begin
					far_q <= 1'b1;
					far_idx_q <= idx_s1;
					far_d_q <= tag_gap;
				end
				if ((rd_st == ST_PENDING) && (!pend_q || (tag_gap < pend_d_q))) begin
					pend_q <= 1'b1;
					pend_idx_q <= idx_s1;
					pend_d_q <= tag_gap;
					pend_tag_q <= rd_tag;
				end
				if (plus_near) begin
					plus_map_q[diff_up[3:0]] <= 1'b1;
				end
				if (minus_near) begin
					minus_map_q[diff_dn[3:0]] <= 1'b1;
				end
			end
		end
	end

	assign claim_we = cmd_i.emit && ((cmd_i.res_sel == RES_CLAIM) || (cmd_i.res_sel == RES_PREF));
	assign mem_we = claim_we || (cmd_i.emit && (cmd_i.res_sel == RES_REPORT) && rpt_apply);
	assign mem_wa = claim_we ? claim_idx : SW'(rslot_q);

	always_comb begin
		if (claim_we) begin
			mem_wd = {((cmd_i.res_sel == RES_PREF) ? cand[TAG_W-1:0] : item_q), ST_PENDING};
		end else begin
			mem_wd = {rd_tag, rpt_st};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem_q[mem_wa] <= mem_wd;
		end
		if (rd_en) begin
			rd_s1 <= slot_mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd_i.flush) begin
			valid_q <= '0;
		end else if (claim_we) begin
			valid_q[claim_idx] <= 1'b1;
		end
	end

	always_comb begin
		res_slot = '0;
		res_item = '0;
		res_hit = 1'b0;
		res_st = ST_PENDING;
		res_found = 1'b0;
		unique case (cmd_i.res_sel)
			RES_ZERO: begin
			end
			RES_MATCH: begin
				res_slot = OUT_SLOT_W'(match_idx_q);
				res_item = item_q;
				res_hit = 1'b1;
				res_st = match_st_q;
			end
			RES_CLAIM: begin
				res_slot = OUT_SLOT_W'(claim_idx);
				res_item = item_q;
			end
			RES_PEND: begin
				res_slot = OUT_SLOT_W'(pend_idx_q);
				res_item = pend_tag_q;
				res_hit = 1'b1;
				res_found = 1'b1;
			end
			RES_PREF: begin
				res_slot = OUT_SLOT_W'(claim_idx);
				res_item = cand[TAG_W-1:0];
				res_found = 1'b1;
			end
			RES_REPORT: begin
				res_slot = rslot_q;
				if (rpt_in && rd_v) begin
					res_item = rd_tag;
					res_hit = rpt_apply;
					res_st = rpt_apply ? rpt_st : rd_st;
					res_found = rpt_apply;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd_i.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.emit) begin
			slot_index_q <= res_slot;
			slot_item_q <= res_item;
			hit_q <= res_hit;
			load_state_q <= res_st;
			found_q <= res_found;
		end
	end

	assign status_o.op = op_q;
	assign status_o.scan_end = (cnt_q == LAST_CNT);
	assign status_o.match = match_q;
	assign status_o.pend = pend_q;
	assign status_o.zero_count = (item_count_q == '0);
	assign status_o.pref_ok = !pref_end && !skip_minus && cand_below && !slotted;
	assign status_o.pref_end = pref_end;

	assign done = done_q;
	assign slot_index = slot_index_q;
	assign slot_item = slot_item_q;
	assign hit = hit_q;
	assign load_state = load_state_q;
	assign found = found_q;

	`CHK_IMPLIES(claim_has_victim, clk, arst_n, claim_we && !free_q, far_q,
		"claim with no free or far slot")
	`CHK_IMPLIES(pend_result_known, clk, arst_n, cmd_i.emit && (cmd_i.res_sel == RES_PEND),
		pend_q, "pending result with no pending slot")
	`CHK_NEVER(scan_in_range, clk, arst_n, cnt_q > LAST_CNT, "scan counter past slot count")

endmodule
